[design/fpwc_pkg.sv]
package fpwc_pkg;

  localparam logic [29:0] PRIME = 30'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);
  localparam logic [6:0] ALPHABET_RESET = 7'd52;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FORBID,
    ST_START,
    ST_INIT,
    ST_LOOP,
    ST_MUL_R,
    ST_COPY_R,
    ST_SHIFT,
    ST_MUL_B,
    ST_COPY_B,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_MUL_R,
    OP_COPY_R,
    OP_MUL_B,
    OP_COPY_B,
    OP_SUM
  } op_t;

  typedef struct packed {
    logic take;
    logic forbid_write;
    logic start;
    op_t  op;
    logic shift;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic exp_zero;
    logic exp_bit0;
    logic exp_hi_zero;
    logic n_zero;
    logic out_free;
  } status_t;

  function automatic logic [29:0] mod_add(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, PRIME}) ? 30'(s - {1'b0, PRIME}) : 30'(s);
  endfunction

endpackage

[design/fpwc_ram.sv]
module fpwc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/fpwc_ctrl.sv]
module fpwc_ctrl import fpwc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    mode,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.op = OP_INIT;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = mode ? ST_START : ST_FORBID;
        end
      end
      ST_FORBID: begin
        cmd.forbid_write = 1'b1;
        state_next = ST_IDLE;
      end
      ST_START: begin
        if (status.n_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.start = 1'b1;
          cmd.op = OP_INIT;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        if (status.done) state_next = ST_LOOP;
      end
      ST_LOOP: begin
        priority if (status.exp_zero) begin
          cmd.start = 1'b1;
          cmd.op = OP_SUM;
          state_next = ST_SUM;
        end else if (status.exp_bit0) begin
          cmd.start = 1'b1;
          cmd.op = OP_MUL_R;
          state_next = ST_MUL_R;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_MUL_R: begin
        if (status.done) begin
          cmd.start = 1'b1;
          cmd.op = OP_COPY_R;
          state_next = ST_COPY_R;
        end
      end
      ST_COPY_R: begin
        if (status.done) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.exp_hi_zero) begin
          state_next = ST_LOOP;
        end else begin
          cmd.start = 1'b1;
          cmd.op = OP_MUL_B;
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (status.done) begin
          cmd.start = 1'b1;
          cmd.op = OP_COPY_B;
          state_next = ST_COPY_B;
        end
      end
      ST_COPY_B: begin
        if (status.done) state_next = ST_LOOP;
      end
      ST_SUM: begin
        if (status.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[design/fpwc_dp.sv]
module fpwc_dp import fpwc_pkg::*; #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  input  logic [5:0]  from_symbol,
  input  logic [5:0]  to_symbol,
  input  logic [62:0] sequence_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] sequence_count
);

  localparam int SYM_W  = $clog2(MAX_SYMBOLS);
  localparam int ADDR_W = 2 * SYM_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic [31:0] PRIME2 = 32'({2'b0, PRIME} << 1);

  typedef struct packed {
    logic             valid;
    logic             mul;
    logic             first;
    logic             last_z;
    logic             last;
    logic [SYM_W-1:0] i;
    logic [SYM_W-1:0] j;
  } tag_t;

  logic [6:0]             alphabet;
  logic [6:0]             n_sat;
  logic [SYM_W-1:0]       nm1;
  logic                   n_zero;
  logic [62:0]            exp_left;
  logic [SYM_W-1:0]       f_sym;
  logic [SYM_W-1:0]       t_sym;
  logic                   pair_ok;
  logic [MAX_SYMBOLS-1:0] row_valid;

  op_t                    op;
  logic                   issuing;
  logic [SYM_W-1:0]       i_cnt, j_cnt, z_cnt;
  logic                   is_mul, i_end, j_end, z_end;
  tag_t                   tag0;
  tag_t                   tags [1:5];

  logic [29:0]            acc;
  logic [29:0]            sum5;
  logic [59:0]            prod, prod2;
  logic [61:0]            barrett;
  logic [31:0]            qp, p3, diff;
  logic [29:0]            r4;
  logic [29:0]            mul_a;

  logic [ADDR_W-1:0]      addr_iz, addr_zj, addr_ij, addr_t1, addr_t5;
  logic [MAX_SYMBOLS-1:0] allow_rd, allow_wdata, allow_row;
  logic [SYM_W-1:0]       allow_raddr;
  logic                   allow_we;
  logic                   init_bit;
  logic [29:0]            base_a_rd, base_b_rd, result_rd, scratch_rd;
  logic                   base_we, result_we, scratch_we;
  logic [29:0]            base_wdata, result_wdata;
  logic [ADDR_W-1:0]      result_raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet <= ALPHABET_RESET;
    end else if (cfg_write) begin
      alphabet <= cfg_data;
    end
  end

  assign n_sat = (alphabet > 7'(MAX_SYMBOLS)) ? 7'(MAX_SYMBOLS) : alphabet;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_left <= '0;
    end else if (cmd.take) begin
      exp_left <= (sequence_length == 63'd0) ? 63'd0 : sequence_length - 63'd1;
    end else if (cmd.shift) begin
      exp_left <= exp_left >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      nm1     <= SYM_W'(n_sat - 7'd1);
      n_zero  <= (alphabet == 7'd0);
      f_sym   <= from_symbol[SYM_W-1:0];
      t_sym   <= to_symbol[SYM_W-1:0];
      pair_ok <= ({1'b0, from_symbol} < 7'(MAX_SYMBOLS))
                 && ({1'b0, to_symbol} < 7'(MAX_SYMBOLS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      row_valid <= '0;
    end else if (allow_we) begin
      row_valid[f_sym] <= 1'b1;
    end
  end

  assign allow_we    = cmd.forbid_write && pair_ok;
  assign allow_row   = row_valid[f_sym] ? allow_rd : '1;
  assign allow_wdata = allow_row & ~(MAX_SYMBOLS'(1) << t_sym);
  assign allow_raddr = (issuing && op == OP_INIT) ? i_cnt : from_symbol[SYM_W-1:0];

  assign is_mul = (op == OP_MUL_R) || (op == OP_MUL_B);
  assign i_end  = (i_cnt == nm1);
  assign j_end  = (j_cnt == nm1);
  assign z_end  = (z_cnt == nm1);

  always_comb begin
    tag0.valid  = issuing;
    tag0.mul    = is_mul;
    tag0.first  = is_mul ? (z_cnt == '0) : (i_cnt == '0 && j_cnt == '0);
    tag0.last_z = z_end;
    tag0.last   = is_mul ? (z_end && j_end && i_end) : (j_end && i_end);
    tag0.i      = i_cnt;
    tag0.j      = j_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      op      <= OP_INIT;
      i_cnt   <= '0;
      j_cnt   <= '0;
      z_cnt   <= '0;
    end else if (cmd.start) begin
      issuing <= 1'b1;
      op      <= cmd.op;
      i_cnt   <= '0;
      j_cnt   <= '0;
      z_cnt   <= '0;
    end else if (issuing) begin
      if (tag0.last) issuing <= 1'b0;
      if (is_mul && !z_end) begin
        z_cnt <= z_cnt + 1'b1;
      end else begin
        z_cnt <= '0;
        if (!j_end) begin
          j_cnt <= j_cnt + 1'b1;
        end else begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 5; k++) tags[k] <= '0;
    end else begin
      tags[1] <= tag0;
      for (int k = 2; k <= 5; k++) tags[k] <= tags[k-1];
    end
  end

  assign mul_a = (op == OP_MUL_R) ? result_rd : base_a_rd;
  assign diff  = p3 - qp;

  always_ff @(posedge clk) begin
    prod    <= 60'(mul_a) * 60'(base_b_rd);
    prod2   <= prod;
    barrett <= 62'(prod[59:29]) * 62'(BARRETT_MU);
    qp      <= 32'(64'(barrett[61:31]) * 64'(PRIME));
    p3      <= prod2[31:0];
    if (diff >= PRIME2) begin
      r4 <= 30'(diff - PRIME2);
    end else if (diff >= 32'(PRIME)) begin
      r4 <= 30'(diff - 32'(PRIME));
    end else begin
      r4 <= 30'(diff);
    end
  end

  assign sum5 = mod_add(tags[5].first ? 30'd0 : acc, r4);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (tags[5].valid && tags[5].mul) begin
      acc <= sum5;
    end else if (tags[1].valid && op == OP_SUM) begin
      acc <= mod_add(tags[1].first ? 30'd0 : acc, result_rd);
    end
  end

  assign addr_iz  = {i_cnt, z_cnt};
  assign addr_zj  = {z_cnt, j_cnt};
  assign addr_ij  = {i_cnt, j_cnt};
  assign addr_t1  = {tags[1].i, tags[1].j};
  assign addr_t5  = {tags[5].i, tags[5].j};
  assign init_bit = row_valid[tags[1].i] ? allow_rd[tags[1].j] : 1'b1;

  assign base_we      = tags[1].valid && (op == OP_INIT || op == OP_COPY_B);
  assign base_wdata   = (op == OP_INIT) ? 30'(init_bit) : scratch_rd;
  assign result_we    = tags[1].valid && (op == OP_INIT || op == OP_COPY_R);
  assign result_wdata = (op == OP_INIT) ? 30'(tags[1].i == tags[1].j) : scratch_rd;
  assign result_raddr = (op == OP_SUM) ? addr_ij : addr_iz;
  assign scratch_we   = tags[5].valid && tags[5].mul && tags[5].last_z;

  fpwc_ram #(.WIDTH(MAX_SYMBOLS), .DEPTH(1 << SYM_W)) u_allowed (
    .clk(clk), .we(allow_we), .waddr(f_sym), .wdata(allow_wdata),
    .raddr(allow_raddr), .rdata(allow_rd)
  );

  fpwc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_base_a (
    .clk(clk), .we(base_we), .waddr(addr_t1), .wdata(base_wdata),
    .raddr(addr_iz), .rdata(base_a_rd)
  );

  fpwc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_base_b (
    .clk(clk), .we(base_we), .waddr(addr_t1), .wdata(base_wdata),
    .raddr(addr_zj), .rdata(base_b_rd)
  );

  fpwc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_result (
    .clk(clk), .we(result_we), .waddr(addr_t1), .wdata(result_wdata),
    .raddr(result_raddr), .rdata(result_rd)
  );

  fpwc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_scratch (
    .clk(clk), .we(scratch_we), .waddr(addr_t5), .wdata(sum5),
    .raddr(addr_ij), .rdata(scratch_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sequence_count <= n_zero ? 30'd0 : acc;
    end
  end

  always_comb begin
    status.done        = (tags[1].valid && tags[1].last && !tags[1].mul)
                         || (tags[5].valid && tags[5].last && tags[5].mul);
    status.exp_zero    = (exp_left == 63'd0);
    status.exp_bit0    = exp_left[0];
    status.exp_hi_zero = (exp_left[62:1] == 62'd0);
    status.n_zero      = n_zero;
    status.out_free    = !out_valid || out_ready;
  end

endmodule

[design/forbidden_pair_walk_counter_unit.sv]
// Counts sequences of sequence_length symbols over an alphabet of alphabet_size symbols
// (saturated at MAX_SYMBOLS) that avoid every forbidden ordered pair, modulo 1000000007.
// A forbid item (mode 0) emits nothing. A run item (mode 1) builds the matrices, then for
// each bit of (length - 1) does up to two matrix products, each followed by a copy, and a
// final sum; the products run on the single pipelined multiply and Barrett-reduce unit, fed
// from one read port per matrix store. With an empty alphabet it goes straight to emitting
// zero. It emits one item and restores every pair to allowed.
module forbidden_pair_walk_counter_unit import fpwc_pkg::*; #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [5:0]  from_symbol,
  input  logic [5:0]  to_symbol,
  input  logic [62:0] sequence_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] sequence_count
);

  cmd_t    cmd;
  status_t status;

  fpwc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .status(status), .cmd(cmd)
  );

  fpwc_dp #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .from_symbol(from_symbol), .to_symbol(to_symbol),
    .sequence_length(sequence_length),
    .out_valid(out_valid), .out_ready(out_ready), .sequence_count(sequence_count)
  );

endmodule
